FILE: src/sll_pkg.sv
// Package for the static linked list engine: operation and status codes,
// sequencer states and the default store size. No dependencies.
package sll_pkg;

  localparam int SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_DELETE  = 2'd1,
    FN_FIND    = 2'd2,
    FN_REPLACE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_FREE,
    S_INS_TAKE,
    S_INS_LINK,
    S_INS_HOOK,
    S_SRCH_FIRST,
    S_SRCH_NODE,
    S_DEL_FREE,
    S_DEL_LINK,
    S_DEL_HOOK
  } state_t;

endpackage

FILE: src/sll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sll_link_store.sv
// Link store: RAM of next links plus one valid bit per slot; a slot never
// written reads as its reset link (free chain from slot 2, head empty).
// Depends on sll_ram.
module sll_link_store #(
  parameter int SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  logic [$clog2(SLOTS)-1:0] wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output logic [$clog2(SLOTS)-1:0] rdata
);

  localparam int IW = $clog2(SLOTS);

  logic [SLOTS-1:0] vld;
  logic             vld_q;
  logic [IW-1:0]    addr_q;
  logic [IW-1:0]    ram_q;
  logic [IW:0]      inc;
  logic [IW-1:0]    init_link;

  sll_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
    vld_q  <= vld[raddr];
    addr_q <= raddr;
  end

  // reset link: slot 0 -> 2, head and last slot -> 0, others -> next slot
  always_comb begin
    inc = {1'b0, addr_q} + (IW+1)'(1);
    if (addr_q == '0) begin
      init_link = IW'(2);
    end else if (addr_q == IW'(1) || addr_q == IW'(SLOTS-1)) begin
      init_link = '0;
    end else begin
      init_link = inc[IW-1:0];
    end
  end

  assign rdata = vld_q ? ram_q : init_link;

endmodule

FILE: src/static_linked_list_engine.sv
// Static linked list engine: top level with the operation sequencer.
// Depends on sll_pkg, sll_link_store and sll_ram.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low;
//   func, position, value and new_value are captured then. busy stays high
//   while the sequencer walks the node store. The result (status, slot) is
//   presented for exactly one cycle with done high; the receiver cannot
//   stall, so it must take the result in that cycle.
// Sequence of operations:
//   insert            : walk to position (position 0 counts as 1), read the
//                       free chain head, then take, link and hook the slot
//   find / replace    : read the first node, then one node per hop to the match
//   delete            : as find, then the unlink, link and hook writes
//   misses end after the last node, beyond-end as soon as the walk runs out.
//   The steps are set by the link store: one registered read per hop, and
//   each link update is one write of its single write port.
//   A new transaction may be started in the cycle that shows done.
// Reset: synchronous, active high. The list is empty, slots 2 and up form
//   the free chain (valid bits in the link store, so no clearing pass).
//   Node bytes are undefined until written; only written ones are read.
module static_linked_list_engine #(
  parameter int SLOTS = sll_pkg::SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  logic [4:0] position,
  input  logic [7:0] value,
  input  logic [7:0] new_value,
  output logic       busy,
  output logic       done,
  output logic [1:0] status,
  output logic [3:0] slot
);

  import sll_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] HEAD      = IW'(1);
  localparam logic [IW-1:0] FREE_HEAD = '0;

  state_t        state, state_next;

  // captured request
  func_t         func_q, func_q_next;
  logic [4:0]    pos_q, pos_q_next;
  logic [7:0]    val_q, val_q_next;
  logic [7:0]    nval_q, nval_q_next;

  // walk registers: at = insert point / predecessor, cur = fresh / hit slot
  logic [IW-1:0] at, at_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] nxt, nxt_next;   // saved link of at (insert) or of hit
  logic [IW-1:0] fr, fr_next;     // free chain head (delete)
  logic [4:0]    hop_i, hop_i_next;
  logic [IW:0]   hops, hops_next;
  logic [IW:0]   hops_inc;

  // result
  logic          done_next;
  status_t       status_q, status_q_next;
  logic [3:0]    slot_q, slot_q_next;
  logic [IW+3:0] cur_wide;

  // store ports
  logic [IW-1:0] raddr;
  logic          lk_we;
  logic [IW-1:0] lk_waddr, lk_wdata, lk_rdata;
  logic          nv_we;
  logic [IW-1:0] nv_waddr;
  logic [7:0]    nv_wdata, nv_rdata;

  sll_link_store #(.SLOTS(SLOTS)) u_links (
    .clk   (clk),
    .rst   (rst),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (raddr),
    .rdata (lk_rdata)
  );

  sll_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_values (
    .clk   (clk),
    .we    (nv_we),
    .waddr (nv_waddr),
    .wdata (nv_wdata),
    .raddr (raddr),
    .rdata (nv_rdata)
  );

  assign hops_inc = hops + (IW+1)'(1);
  assign cur_wide = {4'b0, cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= done_next;
    end
    func_q   <= func_q_next;
    pos_q    <= pos_q_next;
    val_q    <= val_q_next;
    nval_q   <= nval_q_next;
    at       <= at_next;
    cur      <= cur_next;
    nxt      <= nxt_next;
    fr       <= fr_next;
    hop_i    <= hop_i_next;
    hops     <= hops_next;
    status_q <= status_q_next;
    slot_q   <= slot_q_next;
  end

  always_comb begin
    state_next    = state;
    func_q_next   = func_q;
    pos_q_next    = pos_q;
    val_q_next    = val_q;
    nval_q_next   = nval_q;
    at_next       = at;
    cur_next      = cur;
    nxt_next      = nxt;
    fr_next       = fr;
    hop_i_next    = hop_i;
    hops_next     = hops;
    status_q_next = status_q;
    slot_q_next   = slot_q;
    done_next     = 1'b0;
    raddr         = '0;
    lk_we         = 1'b0;
    lk_waddr      = '0;
    lk_wdata      = '0;
    nv_we         = 1'b0;
    nv_waddr      = '0;
    nv_wdata      = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          func_q_next = func_t'(func);
          pos_q_next  = position;
          val_q_next  = value;
          nval_q_next = new_value;
          at_next     = HEAD;
          hop_i_next  = 5'd1;
          raddr       = HEAD;
          state_next  = (func_t'(func) == FN_INSERT) ? S_INS_WALK : S_SRCH_FIRST;
        end
      end

      // lk_rdata is the link of at
      S_INS_WALK: begin
        if (hop_i < pos_q) begin
          at_next = lk_rdata;
          if (lk_rdata == '0) begin
            status_q_next = ST_BEYOND;
            slot_q_next   = '0;
            done_next     = 1'b1;
            state_next    = S_IDLE;
          end else begin
            raddr      = lk_rdata;
            hop_i_next = hop_i + 5'd1;
          end
        end else begin
          nxt_next   = lk_rdata;
          raddr      = FREE_HEAD;
          state_next = S_INS_FREE;
        end
      end

      S_INS_FREE: begin
        if (lk_rdata == '0) begin
          status_q_next = ST_FULL;
          slot_q_next   = '0;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cur_next   = lk_rdata;
          raddr      = lk_rdata;
          state_next = S_INS_TAKE;
        end
      end

      // pop fresh slot off the free chain and store the byte
      S_INS_TAKE: begin
        lk_we      = 1'b1;
        lk_waddr   = FREE_HEAD;
        lk_wdata   = lk_rdata;
        nv_we      = 1'b1;
        nv_waddr   = cur;
        nv_wdata   = val_q;
        state_next = S_INS_LINK;
      end

      S_INS_LINK: begin
        lk_we      = 1'b1;
        lk_waddr   = cur;
        lk_wdata   = nxt;
        state_next = S_INS_HOOK;
      end

      S_INS_HOOK: begin
        lk_we         = 1'b1;
        lk_waddr      = at;
        lk_wdata      = cur;
        status_q_next = ST_OK;
        slot_q_next   = cur_wide[3:0];
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end

      // lk_rdata is the first node after the head
      S_SRCH_FIRST: begin
        cur_next  = lk_rdata;
        hops_next = '0;
        if (lk_rdata == '0) begin
          status_q_next = ST_NOT_FOUND;
          slot_q_next   = '0;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          raddr      = lk_rdata;
          state_next = S_SRCH_NODE;
        end
      end

      // byte and link of cur are on the read ports
      S_SRCH_NODE: begin
        if (nv_rdata == val_q) begin
          case (func_q)
            FN_DELETE: begin
              nxt_next   = lk_rdata;
              raddr      = FREE_HEAD;
              state_next = S_DEL_FREE;
            end
            FN_REPLACE: begin
              nv_we         = 1'b1;
              nv_waddr      = cur;
              nv_wdata      = nval_q;
              status_q_next = ST_OK;
              slot_q_next   = cur_wide[3:0];
              done_next     = 1'b1;
              state_next    = S_IDLE;
            end
            default: begin
              status_q_next = ST_OK;
              slot_q_next   = cur_wide[3:0];
              done_next     = 1'b1;
              state_next    = S_IDLE;
            end
          endcase
        end else begin
          at_next   = cur;
          cur_next  = lk_rdata;
          hops_next = hops_inc;
          if (lk_rdata == '0 || hops_inc == (IW+1)'(SLOTS)) begin
            status_q_next = ST_NOT_FOUND;
            slot_q_next   = '0;
            done_next     = 1'b1;
            state_next    = S_IDLE;
          end else begin
            raddr = lk_rdata;
          end
        end
      end

      // unlink the hit, then push it on the free chain
      S_DEL_FREE: begin
        fr_next    = lk_rdata;
        lk_we      = 1'b1;
        lk_waddr   = at;
        lk_wdata   = nxt;
        state_next = S_DEL_LINK;
      end

      S_DEL_LINK: begin
        lk_we      = 1'b1;
        lk_waddr   = cur;
        lk_wdata   = fr;
        state_next = S_DEL_HOOK;
      end

      S_DEL_HOOK: begin
        lk_we         = 1'b1;
        lk_waddr      = FREE_HEAD;
        lk_wdata      = cur;
        status_q_next = ST_OK;
        slot_q_next   = cur_wide[3:0];
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign status = status_q;
  assign slot   = slot_q;

  // a transaction always leaves idle before its result, so results never abut
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for more than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while sequencer still busy");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    done && status_q != ST_OK |-> slot == 4'd0)
    else $error("failed transaction reported a slot");

  a_no_link_to_free_head: assert property (@(posedge clk) disable iff (rst)
    lk_we && lk_waddr != FREE_HEAD |-> lk_wdata != HEAD)
    else $error("link written to point at the list head");

endmodule
